/* design/fdn_reverb_8_line_core_assert.svh */
// Assertion macros for the feedback delay network reverb core.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef FDN_REVERB_8_LINE_CORE_ASSERT_SVH
`define FDN_REVERB_8_LINE_CORE_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define FDN_ASSERT_SAME(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("fdn assertion failed");

// Checks that a condition implies another in the next cycle.
`define FDN_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("fdn assertion failed");

`endif

/* design/fdn_pkg.sv */
// Package of the feedback delay network reverb: types, register indexes,
// sign tables and the saturation helper. Depends on nothing.
package fdn_pkg;

    localparam int SampleBits = 16;
    localparam int NumLines   = 8;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_MIX      = 3'd0,
        CFG_LEN_LO   = 3'd1,
        CFG_LEN_HI   = 3'd2,
        CFG_COEF_01  = 3'd3,
        CFG_COEF_23  = 3'd4,
        CFG_COEF_45  = 3'd5,
        CFG_COEF_67  = 3'd6,
        CFG_UNUSED   = 3'd7
    } t_cfg_index;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_RADDR,
        ST_RDATA,
        ST_FILT,
        ST_MIX,
        ST_DONE
    } t_state;

    // Filter coefficients of one line.
    typedef struct packed {
        logic signed [15:0] b0;
        logic signed [15:0] a1;
    } t_coef;

    // Handshake between the sequencer and a serial unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

    // A set bit marks a negative sign for that line.
    localparam logic [7:0] SignLeftNeg  = 8'b1010_1010;
    localparam logic [7:0] SignRightNeg = 8'b1001_1001;

    localparam logic [15:0] MixUnity = 16'd32768;

    // Saturates a wide signed value to the sample range.
    function automatic logic signed [15:0] sat_sample(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -40'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* design/fdn_reverb_8_line_core.sv */
// Top level of the eight-line feedback delay network reverb: sequencer,
// delay memory, configuration registers. Uses fdn_pkg, fdn_mac, fdn_mix.
//
// Usage: one mono sample enters on the input channel (i_in_valid,
// o_in_ready, i_sample_in) and one stereo pair leaves on the output
// channel (o_out_valid, i_out_ready, o_left_out, o_right_out). Registers
// are written on the configuration channel (i_cfg_valid, o_cfg_ready,
// i_cfg_index, i_cfg_data), which is always ready; write it only while idle.
// One request is processed at a time: it is accepted, the delay writes are
// made for the eight lines, each line then has its tap read and the 16-step
// bit-serial filter, and the bit-serial mix runs before the output register
// is loaded. The serial filter unit is shared by the eight lines.
// After reset the delay memory is cleared, one entry per cycle, all
// 8 * 2^clog2(LINE_DEPTH) entries (262144 at the default), before the first
// request is taken. When the receiver stalls, the finished pair waits in the
// output register; the next request is taken and processed meanwhile, and it
// waits for the output register before its own pair is loaded.
module fdn_reverb_8_line_core #(
    parameter int LINE_DEPTH = 32768
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [15:0]   i_sample_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [15:0]   o_left_out,
    output logic signed [15:0]   o_right_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    import fdn_pkg::*;

    localparam int PW = $clog2(LINE_DEPTH);
    localparam int AW = PW + 3;

    // Configuration registers.
    logic [15:0] r_mix;
    logic [63:0] r_len_lo;
    logic [63:0] r_len_hi;
    logic [63:0] r_coef [4];

    // Sequencer and data path state.
    t_state             r_state;
    t_state             n_state;
    logic [2:0]         r_line;
    logic [AW-1:0]      r_clr;
    logic [PW-1:0]      r_ptr;
    logic signed [15:0] r_x;
    logic signed [18:0] r_sum;
    logic signed [18:0] r_sl;
    logic signed [18:0] r_sr;
    logic signed [15:0] r_fo [NumLines];
    logic signed [15:0] r_rd;
    logic               r_out_valid;
    logic signed [15:0] r_left;
    logic signed [15:0] r_right;

    logic signed [15:0] mem [8 << PW];

    // Decoded strobes.
    logic               in_acc;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [15:0] mem_wd;
    logic               mem_re;
    logic [AW-1:0]      mem_ra;
    logic               mac_start;
    logic               mix_start;
    logic               out_load;
    logic               last_clr;
    logic               last_line;

    logic signed [20:0] dl_v;
    logic signed [39:0] dl_r;
    logic signed [18:0] fo_sum;
    logic signed [18:0] sl_next;
    logic signed [18:0] sr_next;
    logic [63:0]        len_reg;
    logic [15:0]        len;
    logic [15:0]        len_m1;
    logic [PW-1:0]      off;
    logic [PW:0]        idx;
    logic [63:0]        coef_reg;
    t_coef              coef;
    logic [15:0]        wet;
    logic [15:0]        dry;

    t_unit_status       mac_st;
    t_unit_status       mix_st;
    logic signed [15:0] mac_y;
    logic signed [15:0] mix_l;
    logic signed [15:0] mix_r;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;
    assign in_acc      = i_in_valid && o_in_ready;
    assign last_clr    = (r_clr == '1);
    assign last_line   = (r_line == 3'd7);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix    <= 16'd16384;
            r_len_lo <= '0;
            r_len_hi <= '0;
            r_coef   <= '{default: '0};
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MIX:     r_mix     <= i_cfg_data[15:0];
                CFG_LEN_LO:  r_len_lo  <= i_cfg_data;
                CFG_LEN_HI:  r_len_hi  <= i_cfg_data;
                CFG_COEF_01: r_coef[0] <= i_cfg_data;
                CFG_COEF_23: r_coef[1] <= i_cfg_data;
                CFG_COEF_45: r_coef[2] <= i_cfg_data;
                CFG_COEF_67: r_coef[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sum of the previous filter outputs.
    always_comb begin
        fo_sum = '0;
        for (int j = 0; j < NumLines; j++) begin
            fo_sum = fo_sum + 19'(r_fo[j]);
        end
    end

    // Delay line input: o_j - sum/4 + x, rounded and saturated.
    always_comb begin
        dl_v = (21'(r_fo[r_line]) <<< 2) - 21'(r_sum) + (21'(r_x) <<< 2);
        dl_r = (40'(dl_v) + 40'sd2) >>> 2;
    end

    // Tap address of the current line.
    always_comb begin
        len_reg = r_line[2] ? r_len_hi : r_len_lo;
        len     = len_reg[16 * r_line[1:0] +: 16];
        len_m1  = (len == 16'd0) ? 16'd0 : len - 16'd1;
        if (32'(len_m1) > 32'(LINE_DEPTH - 1)) begin
            off = PW'(LINE_DEPTH - 1);
        end else begin
            off = PW'(len_m1);
        end
        idx = {1'b0, r_ptr} - {1'b0, off}
            + ((r_ptr >= off) ? (PW + 1)'(0) : (PW + 1)'(LINE_DEPTH));
    end

    // Coefficients of the current line and the mix shares.
    always_comb begin
        coef_reg = r_coef[r_line[2:1]];
        coef.b0  = coef_reg[32 * r_line[0] +: 16];
        coef.a1  = coef_reg[32 * r_line[0] + 16 +: 16];
        wet      = (r_mix > MixUnity) ? MixUnity : r_mix;
        dry      = MixUnity - wet;
    end

    // Signed sums including the filter output that is just finishing.
    always_comb begin
        sl_next = SignLeftNeg[r_line] ? r_sl - 19'(mac_y) : r_sl + 19'(mac_y);
        sr_next = SignRightNeg[r_line] ? r_sr - 19'(mac_y) : r_sr + 19'(mac_y);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (last_clr) n_state = ST_IDLE;
            ST_IDLE:  if (in_acc) n_state = ST_WRITE;
            ST_WRITE: if (last_line) n_state = ST_RADDR;
            ST_RADDR: n_state = ST_RDATA;
            ST_RDATA: n_state = ST_FILT;
            ST_FILT: begin
                if (mac_st.done) n_state = last_line ? ST_MIX : ST_RADDR;
            end
            ST_MIX:   if (mix_st.done) n_state = ST_DONE;
            ST_DONE:  if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        mem_we    = 1'b0;
        mem_wa    = {r_line, r_ptr};
        mem_wd    = sat_sample(dl_r);
        mem_re    = 1'b0;
        mem_ra    = {r_line, idx[PW-1:0]};
        mac_start = 1'b0;
        mix_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
            end
            ST_WRITE: mem_we = 1'b1;
            ST_RADDR: mem_re = 1'b1;
            ST_RDATA: mac_start = 1'b1;
            ST_FILT:  mix_start = mac_st.done && last_line;
            ST_DONE:  out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_line  <= '0;
            r_ptr   <= '0;
            r_fo    <= '{default: '0};
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (in_acc) r_line <= '0;
            else if (r_state == ST_WRITE || (r_state == ST_FILT && mac_st.done)) begin
                r_line <= r_line + 3'd1;
            end
            if (r_state == ST_FILT && mac_st.done) r_fo[r_line] <= mac_y;
            if (out_load) begin
                r_ptr <= (r_ptr == PW'(LINE_DEPTH - 1)) ? '0 : r_ptr + PW'(1);
            end
        end
    end

    // Per-request data registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x   <= i_sample_in;
            r_sum <= fo_sum;
            r_sl  <= '0;
            r_sr  <= '0;
        end else if (r_state == ST_FILT && mac_st.done) begin
            r_sl <= sl_next;
            r_sr <= sr_next;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_left  <= mix_l;
            r_right <= mix_r;
        end
    end

    // Delay memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd <= mem[mem_ra];
    end

    fdn_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mac_start),
        .i_d      (r_rd),
        .i_y_prev (r_fo[r_line]),
        .i_coef   (coef),
        .o_status (mac_st),
        .o_y      (mac_y)
    );

    // The mixer starts as the last line finishes, so it takes the updated sums.
    fdn_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mix_start),
        .i_sum_l  (sl_next),
        .i_sum_r  (sr_next),
        .i_x      (r_x),
        .i_wet    (wet),
        .i_dry    (dry),
        .o_status (mix_st),
        .o_left   (mix_l),
        .o_right  (mix_r)
    );

    // Checks on the sequencer.
    `include "fdn_reverb_8_line_core_assert.svh"
    `FDN_ASSERT_NEXT(a_accept_starts_write, in_acc, r_state == ST_WRITE && r_line == 3'd0)
    `FDN_ASSERT_SAME(a_mac_done_in_filter, mac_st.done, r_state == ST_FILT)
    `FDN_ASSERT_NEXT(a_load_sets_valid, out_load, o_out_valid)
    `FDN_ASSERT_SAME(a_units_exclusive, mac_st.busy, !mix_st.busy)

endmodule

/* design/fdn_mac.sv */
// Bit-serial filter unit: y = b0*d - a1*y_prev, rounded by 2^15 and saturated.
// Walks one bit of d and y_prev per cycle. Depends on fdn_pkg.
module fdn_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [15:0]   i_d,
    input  logic signed [15:0]   i_y_prev,
    input  fdn_pkg::t_coef       i_coef,
    output fdn_pkg::t_unit_status o_status,
    output logic signed [15:0]   o_y
);
    import fdn_pkg::*;

    logic [15:0]        r_dsh;
    logic [15:0]        r_ysh;
    logic signed [33:0] r_b0s;
    logic signed [33:0] r_a1s;
    logic signed [33:0] r_acc;
    logic [3:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic signed [33:0] term;
    logic signed [39:0] rnd;

    // Partial product of the current bit pair; the top bit carries negative weight.
    always_comb begin
        term = (r_dsh[0] ? r_b0s : 34'sd0) - (r_ysh[0] ? r_a1s : 34'sd0);
    end

    // Control of the serial walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand shifters and accumulator.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dsh <= i_d;
            r_ysh <= i_y_prev;
            r_b0s <= 34'(i_coef.b0);
            r_a1s <= 34'(i_coef.a1);
            r_acc <= '0;
        end else if (r_busy) begin
            r_dsh <= {1'b0, r_dsh[15:1]};
            r_ysh <= {1'b0, r_ysh[15:1]};
            r_b0s <= r_b0s <<< 1;
            r_a1s <= r_a1s <<< 1;
            r_acc <= (r_cnt == 4'd15) ? r_acc - term : r_acc + term;
        end
    end

    // Round to nearest, halves up, then saturate.
    always_comb begin
        rnd = (40'(r_acc) + 40'sd16384) >>> 15;
    end

    assign o_y = sat_sample(rnd);
    assign o_status = '{busy: r_busy, done: r_done};

endmodule

/* design/fdn_mix.sv */
// Bit-serial output mixer: wet*S + dry*8*x for left and right, rounded by
// 2^18 and saturated. Walks one bit of wet and dry per cycle. Uses fdn_pkg.
module fdn_mix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [18:0]   i_sum_l,
    input  logic signed [18:0]   i_sum_r,
    input  logic signed [15:0]   i_x,
    input  logic [15:0]          i_wet,
    input  logic [15:0]          i_dry,
    output fdn_pkg::t_unit_status o_status,
    output logic signed [15:0]   o_left,
    output logic signed [15:0]   o_right
);
    import fdn_pkg::*;

    logic [15:0]        r_wsh;
    logic [15:0]        r_dsh;
    logic signed [35:0] r_sls;
    logic signed [35:0] r_srs;
    logic signed [35:0] r_xs;
    logic signed [35:0] r_acc_l;
    logic signed [35:0] r_acc_r;
    logic [3:0]         r_cnt;
    logic               r_busy;
    logic               r_done;
    logic signed [35:0] dry_term;
    logic signed [39:0] rnd_l;
    logic signed [39:0] rnd_r;

    // Control of the serial walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dry term is shared by both channels.
    always_comb begin
        dry_term = r_dsh[0] ? r_xs : 36'sd0;
    end

    // Operand shifters and accumulators.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_wsh   <= i_wet;
            r_dsh   <= i_dry;
            r_sls   <= 36'(i_sum_l);
            r_srs   <= 36'(i_sum_r);
            r_xs    <= 36'(i_x) <<< 3;
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_busy) begin
            r_wsh   <= {1'b0, r_wsh[15:1]};
            r_dsh   <= {1'b0, r_dsh[15:1]};
            r_sls   <= r_sls <<< 1;
            r_srs   <= r_srs <<< 1;
            r_xs    <= r_xs <<< 1;
            r_acc_l <= r_acc_l + (r_wsh[0] ? r_sls : 36'sd0) + dry_term;
            r_acc_r <= r_acc_r + (r_wsh[0] ? r_srs : 36'sd0) + dry_term;
        end
    end

    // Round to nearest, halves up, then saturate.
    always_comb begin
        rnd_l = (40'(r_acc_l) + 40'sd131072) >>> 18;
        rnd_r = (40'(r_acc_r) + 40'sd131072) >>> 18;
    end

    assign o_left   = sat_sample(rnd_l);
    assign o_right  = sat_sample(rnd_r);
    assign o_status = '{busy: r_busy, done: r_done};

endmodule

/* test/fdn_reverb_8_line_checker.sv */
// Checker for the feedback delay network reverb: watches the sample, pair and
// register channels, predicts each stereo pair and compares. Uses fdn_pkg.
`timescale 1ns / 100ps

module fdn_reverb_8_line_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic signed [15:0]   i_sample_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic signed [15:0]   i_left_out,
    input  logic signed [15:0]   i_right_out,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    import fdn_pkg::*;

    localparam int Depth = 32768;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_pair;

    // Shadow of the registers and of the network state.
    logic [15:0]        mix_reg;
    logic [63:0]        len_lo_reg;
    logic [63:0]        len_hi_reg;
    logic [63:0]        coef_reg [4];
    logic signed [15:0] line_mem [NumLines][Depth];
    logic signed [15:0] filt_out [NumLines];
    int unsigned        wr_ptr;
    t_pair              pair_q [$];
    int                 mismatches;

    initial begin
        mix_reg    = 16'd16384;
        len_lo_reg = '0;
        len_hi_reg = '0;
        for (int k = 0; k < 4; k++) coef_reg[k] = '0;
        for (int j = 0; j < NumLines; j++) begin
            filt_out[j] = '0;
            for (int k = 0; k < Depth; k++) line_mem[j][k] = '0;
        end
        wr_ptr     = 0;
        mismatches = 0;
    end

    assign o_fail_count = mismatches;
    assign o_pending    = pair_q.size();

    function automatic longint round_to(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [15:0] clamp_sample(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Runs one sample through the network and returns the stereo pair.
    function automatic t_pair reverb_step(input logic signed [15:0] x);
        longint sum, sl, sr, v, d, b0, a1, y, wet, dry;
        int unsigned len, off, idx;
        logic [63:0] lreg;
        t_pair p;
        sum = 0;
        sl  = 0;
        sr  = 0;
        for (int j = 0; j < NumLines; j++) sum += filt_out[j];
        // Householder feedback into each line at the shared write slot.
        for (int j = 0; j < NumLines; j++) begin
            v = 4 * longint'(filt_out[j]) - sum + 4 * longint'(x);
            line_mem[j][wr_ptr] = clamp_sample(round_to(v, 2));
        end
        // Tap read and one-pole filter per line.
        for (int j = 0; j < NumLines; j++) begin
            lreg = (j < 4) ? len_lo_reg : len_hi_reg;
            len  = lreg[16 * (j % 4) +: 16];
            off  = (len == 0) ? 0 : len - 1;
            if (off > Depth - 1) off = Depth - 1;
            idx  = (wr_ptr + Depth - off) % Depth;
            d    = line_mem[j][idx];
            b0   = $signed(coef_reg[j / 2][32 * (j % 2) +: 16]);
            a1   = $signed(coef_reg[j / 2][32 * (j % 2) + 16 +: 16]);
            y    = b0 * d - a1 * longint'(filt_out[j]);
            filt_out[j] = clamp_sample(round_to(y, 15));
        end
        for (int j = 0; j < NumLines; j++) begin
            sl += SignLeftNeg[j] ? -longint'(filt_out[j]) : longint'(filt_out[j]);
            sr += SignRightNeg[j] ? -longint'(filt_out[j]) : longint'(filt_out[j]);
        end
        wet = (mix_reg > MixUnity) ? 32768 : longint'(mix_reg);
        dry = 32768 - wet;
        p.left  = clamp_sample(round_to(wet * sl + dry * 8 * longint'(x), 18));
        p.right = clamp_sample(round_to(wet * sr + dry * 8 * longint'(x), 18));
        wr_ptr  = (wr_ptr + 1) % Depth;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_pair exp_pair;
        if (i_rst_n) begin
            // Register writes.
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_MIX:     mix_reg     = i_cfg_data[15:0];
                    CFG_LEN_LO:  len_lo_reg  = i_cfg_data;
                    CFG_LEN_HI:  len_hi_reg  = i_cfg_data;
                    CFG_COEF_01: coef_reg[0] = i_cfg_data;
                    CFG_COEF_23: coef_reg[1] = i_cfg_data;
                    CFG_COEF_45: coef_reg[2] = i_cfg_data;
                    CFG_COEF_67: coef_reg[3] = i_cfg_data;
                    default: ;
                endcase
            end
            // Accepted sample requests.
            if (i_in_valid && i_in_ready) pair_q.push_back(reverb_step(i_sample_in));
            // Delivered pairs.
            if (i_out_valid && i_out_ready) begin
                if (pair_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pair L=%0d R=%0d", i_left_out, i_right_out);
                end else begin
                    exp_pair = pair_q.pop_front();
                    if (exp_pair.left !== i_left_out || exp_pair.right !== i_right_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pair mismatch: expected L=%0d R=%0d got L=%0d R=%0d",
                                     exp_pair.left, exp_pair.right, i_left_out, i_right_out);
                    end
                end
            end
        end
    end

endmodule

/* test/tb_fdn_reverb_8_line_core.sv */
// Testbench top for the feedback delay network reverb core: clock, reset,
// stimulus and verdict. Uses fdn_pkg, the core and fdn_reverb_8_line_checker.
`timescale 1ns / 100ps

module tb_fdn_reverb_8_line_core;
    import fdn_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_sample_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_left_out;
    logic signed [15:0] o_right_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;
    int                 fail_count;
    int                 pending;
    logic               quiet;
    logic               hold_req;

    fdn_reverb_8_line_core u_dut (.*);

    fdn_reverb_8_line_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_sample_in(i_sample_in),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_left_out(o_left_out), .i_right_out(o_right_out),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MIX;
        i_cfg_data  = '0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Overall time limit, well above the slowest correct run.
    initial begin
        #4000000;
        $display("[fdn_reverb_8_line_core] ERROR");
        $finish;
    end

    // Receiver side: random stall bursts and one long hold-off.
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offers one sample request, sometimes with a random idle burst before it.
    task automatic send_sample(input logic signed [15:0] x);
        logic ready_seen;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        // Ready is settled mid-cycle; the request is taken at the edge that follows.
        forever begin
            @(negedge i_clk);
            ready_seen = o_in_ready;
            @(posedge i_clk);
            if (ready_seen) break;
        end
    endtask

    // Waits until every pair has arrived and the core has settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand_lengths();
        logic [63:0] r;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 9))
                0:       r[16 * k +: 16] = 16'hffff;
                1:       r[16 * k +: 16] = 16'($urandom);
                2:       r[16 * k +: 16] = 16'd0;
                default: r[16 * k +: 16] = 16'($urandom_range(1, 300));
            endcase
        end
        return r;
    endfunction

    // Coefficients: mostly a stable decaying filter, sometimes anything.
    function automatic logic [63:0] rand_coeffs();
        logic [63:0] r;
        for (int k = 0; k < 2; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                r[32 * k +: 32] = $urandom;
            end else begin
                r[32 * k +: 16]      = 16'($urandom_range(8000, 30000));
                r[32 * k + 16 +: 16] = 16'(-$signed(17'($urandom_range(0, 12000))));
            end
        end
        return r;
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3:    return 16'($signed(17'($urandom_range(0, 2000))) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] mix_val;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: dry path only, zero-length taps.
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shffff);
        drain();

        // Full wet, extreme coefficients, zero, unit and oversized lengths.
        write_reg(CFG_MIX, 64'd32768);
        write_reg(CFG_LEN_LO, {16'd3, 16'hffff, 16'd1, 16'd0});
        write_reg(CFG_LEN_HI, {16'd40000, 16'd2, 16'd5, 16'd32768});
        write_reg(CFG_COEF_01, {16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
        write_reg(CFG_COEF_23, {16'h0000, 16'h8000, 16'hc000, 16'h6000});
        write_reg(CFG_COEF_45, {16'h1000, 16'h7000, 16'h8000, 16'h8000});
        write_reg(CFG_COEF_67, {16'hf000, 16'h5000, 16'h0000, 16'h7fff});
        write_reg(CFG_UNUSED, 64'hffff_ffff_ffff_ffff);
        for (int k = 0; k < 8; k++) send_sample((k % 2) ? 16'sh8000 : 16'sh7fff);
        drain();

        // All dry, then a mix above unity.
        write_reg(CFG_MIX, 64'd0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh1234);
        drain();
        write_reg(CFG_MIX, 64'hffff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh4321);
        drain();

        // Random phases with fresh settings each time.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0:       mix_val = 16'd32768;
                1:       mix_val = 16'd0;
                2:       mix_val = 16'hffff;
                default: mix_val = 16'($urandom);
            endcase
            write_reg(CFG_MIX, {48'd0, mix_val});
            write_reg(CFG_LEN_LO, rand_lengths());
            write_reg(CFG_LEN_HI, rand_lengths());
            write_reg(CFG_COEF_01, rand_coeffs());
            write_reg(CFG_COEF_23, rand_coeffs());
            write_reg(CFG_COEF_45, rand_coeffs());
            write_reg(CFG_COEF_67, rand_coeffs());
            if (ph == 5) quiet = 1'b1;
            for (int k = 0; k < 155; k++) begin
                if (ph == 2 && k == 20) hold_req = 1'b1;
                send_sample(rand_sample());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("[fdn_reverb_8_line_core] OK");
        end else begin
            $display("[fdn_reverb_8_line_core] ERROR");
        end
        $finish;
    end

endmodule
